FILE: hw/rtl/fgpa_pkg.sv
// Shared types and constants for the filtered group price aggregator.
// Used by the controller, the datapath and the top level.
package fgpa_pkg;

   localparam int NumGroupsDefault = 8;
   localparam logic [15:0] CutoffReset = 16'd10471;
   localparam logic [7:0] ScaleOne = 8'd100;
   localparam logic OpAccum = 1'b0;
   localparam logic OpFlush = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic capture;    // latch the request into the datapath
      logic mul1;       // register price * (100 - discount)
      logic mul2;       // register discounted * (100 + tax)
      logic update;     // write the accumulators of the matched or newly taken slot
      logic emit_load;  // load the output register from the scan slot
      logic emit_empty; // load the empty-flush marker
      logic scan_next;  // step the flush scan
      logic clear;      // free all slots, clear the drop flag
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_flush;
      logic in_window;
      logic scan_used;
      logic scan_done;
      logic any_emitted;
   } status_type;

endpackage

FILE: hw/rtl/filtered_group_price_aggregator.sv
// Top level of the filtered group price aggregator: cutoff register,
// controller and datapath. Depends on fgpa_pkg, fgpa_controller, fgpa_datapath.
//
// channel   direction  handshake            payload
// req_      in         req_valid/req_ready  opcode, row fields
// rsp_      out        rsp_valid/rsp_ready  group key, sums, flags
// csr_      in         csr_write_enable     cutoff_date
//
// A row that is filtered out is only captured and decoded; an accumulated row
// goes through capture, lookup with the first multiply, second multiply and
// table write. A flush steps the slot scan over every slot and sends one result
// per used slot, or the empty-flush marker when no slot is used.
// Reset is synchronous; it frees all slots and loads the cutoff default.
// A stalled result holds in the output register and the scan waits.
module filtered_group_price_aggregator #(
   parameter int NUM_GROUPS = fgpa_pkg::NumGroupsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [15:0]        req_ship_date,
   input  logic [7:0]         req_return_flag,
   input  logic [7:0]         req_line_status,
   input  logic signed [39:0] req_quantity,
   input  logic signed [39:0] req_extended_price,
   input  logic [6:0]         req_discount,
   input  logic [6:0]         req_tax,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_group_flag,
   output logic [7:0]         rsp_group_status,
   output logic signed [63:0] rsp_sum_quantity,
   output logic signed [63:0] rsp_sum_price,
   output logic signed [63:0] rsp_sum_discounted,
   output logic signed [63:0] rsp_sum_charged,
   output logic [62:0]        rsp_rows_counted,
   output logic               rsp_has_group,
   output logic               rsp_rows_dropped,
   output logic               rsp_last
);
   import fgpa_pkg::*;

   logic [15:0] cutoff_ff;
   cmd_type     cmd;
   status_type  status;

   always_ff @(posedge clock) begin
      if (reset)
         cutoff_ff <= CutoffReset;
      else if (csr_write_enable)
         cutoff_ff <= csr_write_data;
   end

   fgpa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fgpa_datapath #(.NUM_GROUPS(NUM_GROUPS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .cutoff_date        (cutoff_ff),
      .req_opcode         (req_opcode),
      .req_ship_date      (req_ship_date),
      .req_return_flag    (req_return_flag),
      .req_line_status    (req_line_status),
      .req_quantity       (req_quantity),
      .req_extended_price (req_extended_price),
      .req_discount       (req_discount),
      .req_tax            (req_tax),
      .rsp_group_flag     (rsp_group_flag),
      .rsp_group_status   (rsp_group_status),
      .rsp_sum_quantity   (rsp_sum_quantity),
      .rsp_sum_price      (rsp_sum_price),
      .rsp_sum_discounted (rsp_sum_discounted),
      .rsp_sum_charged    (rsp_sum_charged),
      .rsp_rows_counted   (rsp_rows_counted),
      .rsp_has_group      (rsp_has_group),
      .rsp_rows_dropped   (rsp_rows_dropped),
      .rsp_last           (rsp_last)
   );

endmodule

FILE: hw/rtl/fgpa_datapath.sv
// Datapath: request latch, lookup, multiplies, group table and result register.
// Depends on fgpa_pkg.
module fgpa_datapath #(
   parameter int NUM_GROUPS = fgpa_pkg::NumGroupsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fgpa_pkg::cmd_type    cmd,
   output fgpa_pkg::status_type status,
   input  logic [15:0]          cutoff_date,
   input  logic                 req_opcode,
   input  logic [15:0]          req_ship_date,
   input  logic [7:0]           req_return_flag,
   input  logic [7:0]           req_line_status,
   input  logic signed [39:0]   req_quantity,
   input  logic signed [39:0]   req_extended_price,
   input  logic [6:0]           req_discount,
   input  logic [6:0]           req_tax,
   output logic [7:0]           rsp_group_flag,
   output logic [7:0]           rsp_group_status,
   output logic signed [63:0]   rsp_sum_quantity,
   output logic signed [63:0]   rsp_sum_price,
   output logic signed [63:0]   rsp_sum_discounted,
   output logic signed [63:0]   rsp_sum_charged,
   output logic [62:0]          rsp_rows_counted,
   output logic                 rsp_has_group,
   output logic                 rsp_rows_dropped,
   output logic                 rsp_last
);
   import fgpa_pkg::*;

   localparam int IdxW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int CntW = $clog2(NUM_GROUPS + 1);

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (~(a[63] ^ b[63]) & (a[63] ^ s[63]))
         return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      return s;
   endfunction

   logic                 op_ff;
   logic [15:0]          date_ff;
   logic [15:0]          key_ff;
   logic signed [39:0]   qty_ff;
   logic signed [39:0]   price_ff;
   logic [6:0]           disc_ff;
   logic [6:0]           tax_ff;
   logic signed [63:0]   dprice_ff;
   logic signed [63:0]   charge_ff;
   logic                 hit_ff;
   logic                 drop_row_ff;
   logic [IdxW-1:0]      slot_ff;

   logic [NUM_GROUPS-1:0] used_ff;
   logic [15:0]           key_mem   [NUM_GROUPS];
   logic [63:0]           qty_mem   [NUM_GROUPS];
   logic [63:0]           price_mem [NUM_GROUPS];
   logic [63:0]           disc_mem  [NUM_GROUPS];
   logic [63:0]           chg_mem   [NUM_GROUPS];
   logic [62:0]           rows_mem  [NUM_GROUPS];
   logic                  drop_ff;
   logic [CntW-1:0]       scan_ff;
   logic                  emitted_ff;

   // lookup over the captured key, registered with the first multiply
   logic            hit_in, free_in;
   logic [IdxW-1:0] hit_idx, free_idx;
   always_comb begin
      hit_in = 1'b0;
      free_in = 1'b0;
      hit_idx = '0;
      free_idx = '0;
      for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
         if (used_ff[i] && key_mem[i] == key_ff) begin
            hit_in = 1'b1;
            hit_idx = IdxW'(i);
         end
         if (!used_ff[i]) begin
            free_in = 1'b1;
            free_idx = IdxW'(i);
         end
      end
   end

   logic signed [8:0] disc_fac, tax_fac;
   assign disc_fac = $signed({1'b0, ScaleOne}) - $signed({2'b0, disc_ff});
   assign tax_fac  = $signed({1'b0, ScaleOne}) + $signed({2'b0, tax_ff});

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         date_ff  <= req_ship_date;
         key_ff   <= {req_return_flag, req_line_status};
         qty_ff   <= req_quantity;
         price_ff <= req_extended_price;
         disc_ff  <= req_discount;
         tax_ff   <= req_tax;
      end
      if (cmd.mul1) begin
         dprice_ff   <= 64'(price_ff * disc_fac);
         hit_ff      <= hit_in;
         drop_row_ff <= !hit_in && !free_in;
         slot_ff     <= hit_in ? hit_idx : free_idx;
      end
      if (cmd.mul2)
         charge_ff <= 64'(dprice_ff * tax_fac);
      if (cmd.update && !drop_row_ff) begin
         key_mem[slot_ff]   <= key_ff;
         qty_mem[slot_ff]   <= sat_add(hit_ff ? qty_mem[slot_ff] : '0, 64'(qty_ff));
         price_mem[slot_ff] <= sat_add(hit_ff ? price_mem[slot_ff] : '0, 64'(price_ff));
         disc_mem[slot_ff]  <= sat_add(hit_ff ? disc_mem[slot_ff] : '0, dprice_ff);
         chg_mem[slot_ff]   <= sat_add(hit_ff ? chg_mem[slot_ff] : '0, charge_ff);
         rows_mem[slot_ff]  <= !hit_ff ? 63'd1 :
            (&rows_mem[slot_ff]) ? rows_mem[slot_ff] : rows_mem[slot_ff] + 63'd1;
      end
      if (cmd.emit_load) begin
         rsp_group_flag     <= key_mem[scan_ff[IdxW-1:0]][15:8];
         rsp_group_status   <= key_mem[scan_ff[IdxW-1:0]][7:0];
         rsp_sum_quantity   <= qty_mem[scan_ff[IdxW-1:0]];
         rsp_sum_price      <= price_mem[scan_ff[IdxW-1:0]];
         rsp_sum_discounted <= disc_mem[scan_ff[IdxW-1:0]];
         rsp_sum_charged    <= chg_mem[scan_ff[IdxW-1:0]];
         rsp_rows_counted   <= rows_mem[scan_ff[IdxW-1:0]];
         rsp_has_group      <= 1'b1;
         rsp_rows_dropped   <= drop_ff;
      end else if (cmd.emit_empty) begin
         rsp_group_flag     <= '0;
         rsp_group_status   <= '0;
         rsp_sum_quantity   <= '0;
         rsp_sum_price      <= '0;
         rsp_sum_discounted <= '0;
         rsp_sum_charged    <= '0;
         rsp_rows_counted   <= '0;
         rsp_has_group      <= 1'b0;
         rsp_rows_dropped   <= drop_ff;
      end
   end

   // last: the loaded result is the final one when no used slot follows
   logic later_used;
   always_comb begin
      later_used = 1'b0;
      for (int i = 0; i < NUM_GROUPS; i++)
         if (used_ff[i] && CntW'(i) > scan_ff)
            later_used = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         drop_ff    <= 1'b0;
         scan_ff    <= '0;
         emitted_ff <= 1'b0;
         rsp_last   <= 1'b0;
      end else begin
         if (cmd.update) begin
            if (drop_row_ff)
               drop_ff <= 1'b1;
            else
               used_ff[slot_ff] <= 1'b1;
         end
         if (cmd.emit_load) begin
            rsp_last   <= !later_used;
            emitted_ff <= 1'b1;
         end else if (cmd.emit_empty) begin
            rsp_last <= 1'b1;
         end
         if (cmd.scan_next)
            scan_ff <= scan_ff + 1'b1;
         if (cmd.clear) begin
            used_ff    <= '0;
            drop_ff    <= 1'b0;
            scan_ff    <= '0;
            emitted_ff <= 1'b0;
         end
      end
   end

   assign status.is_flush    = (op_ff == OpFlush);
   assign status.in_window   = (date_ff <= cutoff_date);
   assign status.scan_done   = (scan_ff == CntW'(NUM_GROUPS));
   assign status.scan_used   = !status.scan_done && used_ff[scan_ff[IdxW-1:0]];
   assign status.any_emitted = emitted_ff;

endmodule

FILE: hw/rtl/fgpa_controller.sv
// Controller state machine: sequences accumulate and flush requests.
// Depends on fgpa_pkg.
module fgpa_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  fgpa_pkg::status_type status,
   output fgpa_pkg::cmd_type    cmd
);
   import fgpa_pkg::*;

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StDecode = 3'd1;
   localparam logic [2:0] StMul2 = 3'd2;
   localparam logic [2:0] StUpdate = 3'd3;
   localparam logic [2:0] StScan = 3'd4;
   localparam logic [2:0] StOut = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      cmd = '0;
      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = StDecode;
            end
         end
         StDecode: begin
            if (status.is_flush) begin
               state_in = StScan;
            end else if (status.in_window) begin
               cmd.mul1 = 1'b1;
               state_in = StMul2;
            end else begin
               state_in = StIdle;
            end
         end
         StMul2: begin
            cmd.mul2 = 1'b1;
            state_in = StUpdate;
         end
         StUpdate: begin
            cmd.update = 1'b1;
            state_in = StIdle;
         end
         StScan: begin
            // skip free slots; emit a used one, the marker on an empty table, or clear at the end
            if (status.scan_done) begin
               if (status.any_emitted) begin
                  cmd.clear = 1'b1;
                  state_in = StIdle;
               end else begin
                  cmd.emit_empty = 1'b1;
                  valid_in = 1'b1;
                  state_in = StOut;
               end
            end else if (status.scan_used) begin
               cmd.emit_load = 1'b1;
               cmd.scan_next = 1'b1;
               valid_in = 1'b1;
               state_in = StOut;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         StOut: begin
            if (rsp_ready) begin
               valid_in = 1'b0;
               // the empty marker ends the flush; clear once it has gone out
               if (status.scan_done && !status.any_emitted) begin
                  cmd.clear = 1'b1;
                  state_in = StIdle;
               end else begin
                  state_in = StScan;
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: tb/sv/tb_filtered_group_price_aggregator.sv
// Self-checking testbench for filtered_group_price_aggregator: drives rows and flushes,
// predicts each flush result in step with the design and compares field by field.
// Depends on fgpa_pkg and the design's top level only.
`timescale 1ns / 1ps

module tb_filtered_group_price_aggregator;
   import fgpa_pkg::*;

   localparam int NGroups = 8;
   localparam int IdleLimit = 5000;

   typedef struct {
      logic [7:0]         flag;
      logic [7:0]         status;
      logic signed [63:0] qty;
      logic signed [63:0] price;
      logic signed [63:0] disc;
      logic signed [63:0] charge;
      logic [62:0]        rows;
      logic               has_group;
      logic               dropped;
      logic               last;
   } group_summary_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_opcode = OpAccum;
   logic [15:0] req_ship_date = '0;
   logic [7:0] req_return_flag = '0;
   logic [7:0] req_line_status = '0;
   logic signed [39:0] req_quantity = '0;
   logic signed [39:0] req_extended_price = '0;
   logic [6:0] req_discount = '0;
   logic [6:0] req_tax = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_group_flag, rsp_group_status;
   logic signed [63:0] rsp_sum_quantity, rsp_sum_price, rsp_sum_discounted, rsp_sum_charged;
   logic [62:0] rsp_rows_counted;
   logic rsp_has_group, rsp_rows_dropped, rsp_last;

   filtered_group_price_aggregator #(.NUM_GROUPS(NGroups)) dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [15:0]        cutoff_q = CutoffReset;
   logic               used_q[NGroups];
   logic [15:0]        key_q[NGroups];
   logic signed [63:0] sum_qty_q[NGroups], sum_price_q[NGroups];
   logic signed [63:0] sum_disc_q[NGroups], sum_charge_q[NGroups];
   logic [62:0]        rows_q[NGroups];
   logic               dropped_q = 1'b0;

   group_summary_type pending_groups[$];
   int errors = 0;
   int rows_sent = 0, flushes_sent = 0, groups_seen = 0;
   int idle_cycles = 0;
   bit sender_calm = 0, receiver_calm = 0;
   int stall_left = 0;

   initial for (int i = 0; i < NGroups; i++) used_q[i] = 1'b0;

   function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s;
   endfunction

   task automatic predict_flush();
      group_summary_type r;
      int n;
      n = 0;
      for (int i = 0; i < NGroups; i++) begin
         if (used_q[i]) begin
            r.flag = key_q[i][15:8];
            r.status = key_q[i][7:0];
            r.qty = sum_qty_q[i];
            r.price = sum_price_q[i];
            r.disc = sum_disc_q[i];
            r.charge = sum_charge_q[i];
            r.rows = rows_q[i];
            r.has_group = 1'b1;
            r.dropped = dropped_q;
            r.last = 1'b0;
            pending_groups.push_back(r);
            n++;
         end
         used_q[i] = 1'b0;
      end
      if (n == 0) begin
         r = '{default: '0};
         r.dropped = dropped_q;
         pending_groups.push_back(r);
      end
      pending_groups[pending_groups.size() - 1].last = 1'b1;
      dropped_q = 1'b0;
   endtask

   task automatic predict_row(logic [15:0] ship, logic [15:0] key, logic signed [39:0] qty,
                              logic signed [39:0] price, logic [6:0] disc, logic [6:0] tax);
      int slot, free_slot;
      longint dprice, chg;
      slot = -1;
      free_slot = -1;
      if (ship > cutoff_q) return;
      for (int i = 0; i < NGroups; i++) begin
         if (used_q[i] && key_q[i] == key && slot < 0) slot = i;
         if (!used_q[i] && free_slot < 0 && slot < 0) free_slot = i;
      end
      if (slot < 0) begin
         if (free_slot < 0) begin
            dropped_q = 1'b1;
            return;
         end
         slot = free_slot;
         used_q[slot] = 1'b1;
         key_q[slot] = key;
         sum_qty_q[slot] = 0;
         sum_price_q[slot] = 0;
         sum_disc_q[slot] = 0;
         sum_charge_q[slot] = 0;
         rows_q[slot] = 0;
      end
      dprice = longint'(price) * (longint'(100) - longint'(disc));
      chg = dprice * (longint'(100) + longint'(tax));
      sum_qty_q[slot] = sat_add(sum_qty_q[slot], 64'(qty));
      sum_price_q[slot] = sat_add(sum_price_q[slot], 64'(price));
      sum_disc_q[slot] = sat_add(sum_disc_q[slot], dprice);
      sum_charge_q[slot] = sat_add(sum_charge_q[slot], chg);
      if (rows_q[slot] != {63{1'b1}}) rows_q[slot]++;
   endtask

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // send one request; called right after a rising edge
   task automatic send_request(logic op, logic [15:0] ship, logic [15:0] key,
                               logic signed [39:0] qty, logic signed [39:0] price,
                               logic [6:0] disc, logic [6:0] tax);
      int gap;
      gap = sender_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_ship_date <= ship;
      req_return_flag <= key[15:8];
      req_line_status <= key[7:0];
      req_quantity <= qty;
      req_extended_price <= price;
      req_discount <= disc;
      req_tax <= tax;
      do @(posedge clock); while (!req_ready);
      if (op == OpFlush) begin
         predict_flush();
         flushes_sent++;
      end else begin
         predict_row(ship, key, qty, price, disc, tax);
         rows_sent++;
      end
   endtask

   task automatic send_flush();
      send_request(OpFlush, 16'($urandom), 16'($urandom), 40'({$urandom, $urandom}),
                   40'({$urandom, $urandom}), 7'($urandom), 7'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_groups.size() != 0) @(posedge clock);
      // a trailing row may still be in the pipeline
      repeat (12) @(posedge clock);
   endtask

   task automatic set_cutoff(logic [15:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cutoff_q = v;
   endtask

   task automatic send_random_row(int key_pool, bit wide);
      logic [15:0] key, ship;
      logic signed [39:0] qty, price;
      key = wide ? 16'($urandom) : {8'($urandom_range(0, 1) ? 8'hFF : 8'h41 + key_pool),
                                    8'($urandom_range(0, key_pool))};
      ship = wide ? 16'($urandom) : 16'(int'(cutoff_q) + $urandom_range(0, 6) - 4);
      qty = wide ? 40'({$urandom, $urandom}) : 40'($signed(12'($urandom)));
      price = wide ? 40'({$urandom, $urandom}) : 40'($signed(24'($urandom)));
      send_request(OpAccum, ship, key, qty, price, 7'($urandom_range(0, 127)),
                   7'($urandom_range(0, 127)));
   endtask

   task automatic test_directed();
      send_flush();   // empty table right after reset
      send_request(OpAccum, 16'd0, 16'h0000, 40'sh7F_FFFF_FFFF, 40'sh7F_FFFF_FFFF, 7'd0, 7'd0);
      send_request(OpAccum, CutoffReset, 16'hFFFF, -40'sh80_0000_0000, -40'sh80_0000_0000,
                   7'd100, 7'd100);
      send_request(OpAccum, CutoffReset + 16'd1, 16'h0000, 40'sd5, 40'sd5, 7'd1, 7'd1);
      send_request(OpAccum, 16'hFFFF, 16'h1234, 40'sd5, 40'sd5, 7'd1, 7'd1);
      send_request(OpAccum, 16'd100, 16'h0000, 40'sd300, 40'sd1999, 7'd127, 7'd127);
      send_request(OpAccum, 16'd100, 16'hFF00, -40'sd1, 40'sd777, 7'd50, 7'd8);
      send_flush();
      // fill the table, then the ninth and tenth keys are dropped
      for (int i = 0; i < NGroups + 2; i++)
         send_request(OpAccum, 16'd9000, {8'h52, 8'(i)}, 40'(i), 40'(i * 100), 7'd5, 7'd3);
      send_request(OpAccum, 16'd9000, 16'h5201, 40'sd7, 40'sd700, 7'd0, 7'd0);
      send_flush();
      send_flush();   // drop flag cleared by the previous flush
   endtask

   task automatic test_cutoff_extremes();
      set_cutoff(16'd0);
      send_request(OpAccum, 16'd0, 16'h4E4F, 40'sd100, 40'sd100, 7'd10, 7'd10);
      send_request(OpAccum, 16'd1, 16'h4E4F, 40'sd100, 40'sd100, 7'd10, 7'd10);
      send_flush();
      set_cutoff(16'hFFFF);
      send_request(OpAccum, 16'hFFFF, 16'h4146, 40'sd1, 40'sd2, 7'd3, 7'd4);
      send_request(OpAccum, 16'hFFFE, 16'h4146, 40'sd1, 40'sd2, 7'd3, 7'd4);
      send_flush();
   endtask

   // accumulate full-scale rows of both signs into two groups back to back
   task automatic test_large_sums();
      sender_calm = 1;
      for (int i = 0; i < 16; i++) begin
         send_request(OpAccum, 16'd10, 16'h5341, 40'sh7F_FFFF_FFFF, 40'sh7F_FFFF_FFFF,
                      7'd0, 7'd127);
         send_request(OpAccum, 16'd10, 16'h5342, -40'sh80_0000_0000, -40'sh80_0000_0000,
                      7'd0, 7'd127);
      end
      sender_calm = 0;
      send_flush();
   endtask

   task automatic test_random();
      int pool;
      pool = 3;
      for (int n = 0; n < 220; n++) begin
         if (n % 40 == 0) begin
            pool = $urandom_range(1, 12);
            set_cutoff(n == 120 ? 16'($urandom) : 16'($urandom_range(100, 60000)));
         end
         sender_calm = (n >= 160 && n < 200);
         receiver_calm = (n >= 120 && n < 160);
         if (n == 100) drain();   // let every result out before resuming
         if ($urandom_range(0, 11) == 0) send_flush();
         else send_random_row(pool, $urandom_range(0, 9) == 0);
      end
      send_flush();
      sender_calm = 0;
      receiver_calm = 0;
   endtask

   always @(posedge clock) begin
      if (reset || receiver_calm) begin
         rsp_ready <= !reset;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      group_summary_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         groups_seen++;
         if (pending_groups.size() == 0) begin
            $error("unexpected result flag=%0h status=%0h", rsp_group_flag, rsp_group_status);
            errors++;
         end else begin
            e = pending_groups.pop_front();
            if (rsp_group_flag !== e.flag) begin
               $error("group_flag exp %0h got %0h", e.flag, rsp_group_flag); errors++;
            end
            if (rsp_group_status !== e.status) begin
               $error("group_status exp %0h got %0h", e.status, rsp_group_status); errors++;
            end
            if (rsp_sum_quantity !== e.qty) begin
               $error("sum_quantity exp %0d got %0d", e.qty, rsp_sum_quantity); errors++;
            end
            if (rsp_sum_price !== e.price) begin
               $error("sum_price exp %0d got %0d", e.price, rsp_sum_price); errors++;
            end
            if (rsp_sum_discounted !== e.disc) begin
               $error("sum_discounted exp %0d got %0d", e.disc, rsp_sum_discounted); errors++;
            end
            if (rsp_sum_charged !== e.charge) begin
               $error("sum_charged exp %0d got %0d", e.charge, rsp_sum_charged); errors++;
            end
            if (rsp_rows_counted !== e.rows) begin
               $error("rows_counted exp %0d got %0d", e.rows, rsp_rows_counted); errors++;
            end
            if (rsp_has_group !== e.has_group) begin
               $error("has_group exp %0b got %0b", e.has_group, rsp_has_group); errors++;
            end
            if (rsp_rows_dropped !== e.dropped) begin
               $error("rows_dropped exp %0b got %0b", e.dropped, rsp_rows_dropped); errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last exp %0b got %0b", e.last, rsp_last); errors++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_cutoff_extremes();
      test_large_sums();
      test_random();
      drain();
      if (pending_groups.size() != 0) errors++;
      $display("covered %0d rows and %0d flushes, %0d group results checked",
               rows_sent, flushes_sent, groups_seen);
      $display("cutoff extremes, table overflow, empty flush and full-scale sums exercised");
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
